@@ hw/rtl/u8h_pkg.sv @@
package u8h_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam logic [31:0] CpLimit   = 32'h0011_0000;
  localparam logic [31:0] Cp2Byte   = 32'h0000_0080;
  localparam logic [31:0] Cp3Byte   = 32'h0000_0800;
  localparam logic [31:0] Cp4Byte   = 32'h0001_0000;
  localparam logic [31:0] HashTag   = 32'h8000_0000;

  localparam logic [7:0] Lead2 = 8'd192;
  localparam logic [7:0] Lead3 = 8'd224;
  localparam logic [7:0] Lead4 = 8'd240;
  localparam logic [7:0] Cont  = 8'd128;

  // number of bytes minus one
  typedef enum logic [1:0] {
    LEN_1 = 2'd0,
    LEN_2 = 2'd1,
    LEN_3 = 2'd2,
    LEN_4 = 2'd3
  } len_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;    // bytes[0] goes out first
    len_t            len;
    logic            eos;
    logic            invalid;
  } item_t;

endpackage

@@ hw/rtl/u8h_front.sv @@
module u8h_front (
  input  logic           [31:0] code_point,
  input  logic                  end_of_string,
  output u8h_pkg::item_t        item
);
  import u8h_pkg::*;

  always_comb begin
    item         = '0;
    item.eos     = end_of_string;
    item.invalid = (code_point >= CpLimit);
    priority if (item.invalid) begin
      item.len = LEN_1;
    end else if (code_point < Cp2Byte) begin
      item.len      = LEN_1;
      item.bytes[0] = code_point[7:0];
    end else if (code_point < Cp3Byte) begin
      item.len      = LEN_2;
      item.bytes[0] = Lead2 | {3'b000, code_point[10:6]};
      item.bytes[1] = Cont  | {2'b00, code_point[5:0]};
    end else if (code_point < Cp4Byte) begin
      item.len      = LEN_3;
      item.bytes[0] = Lead3 | {4'b0000, code_point[15:12]};
      item.bytes[1] = Cont  | {2'b00, code_point[11:6]};
      item.bytes[2] = Cont  | {2'b00, code_point[5:0]};
    end else begin
      // below the limit, so the top field is at most three bits
      item.len      = LEN_4;
      item.bytes[0] = Lead4 | {5'b00000, code_point[20:18]};
      item.bytes[1] = Cont  | {2'b00, code_point[17:12]};
      item.bytes[2] = Cont  | {2'b00, code_point[11:6]};
      item.bytes[3] = Cont  | {2'b00, code_point[5:0]};
    end
  end

endmodule

@@ hw/rtl/u8h_queue.sv @@
module u8h_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  u8h_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd_en,
  output u8h_pkg::item_t rd_item,
  output logic           rd_valid
);
  import u8h_pkg::*;

  item_t                mem [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr;
  logic [QueueAw-1:0]   rd_ptr;
  logic [QueueAw:0]     count;

  assign full     = (count == (QueueAw+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/u8h_back.sv @@
module u8h_back (
  input  logic                  clk,
  input  logic                  rst,
  input  u8h_pkg::item_t        head,
  input  logic                  head_valid,
  output logic                  head_pop,
  input  logic                  pop,
  output logic                  empty,
  output logic            [7:0] out_byte,
  output logic                  last_of_run,
  output logic                  string_done,
  output logic           [31:0] byte_length,
  output logic           [31:0] string_hash,
  output logic                  invalid_code
);
  import u8h_pkg::*;

  logic        out_valid;
  logic [1:0]  idx;
  logic [31:0] acc;
  logic [31:0] cnt;

  logic        emit;
  logic        last;
  logic        done;
  logic [7:0]  cur_byte;
  logic [31:0] hash_next;
  logic [31:0] cnt_next;

  assign empty = !out_valid;

  always_comb begin
    emit      = head_valid && (!out_valid || pop);
    cur_byte  = head.invalid ? 8'h00 : head.bytes[idx];
    last      = head.invalid || (idx == head.len);
    done      = last && head.eos && !head.invalid;
    // acc * 31 + byte
    hash_next = {acc[26:0], 5'b00000} - acc + {24'h000000, cur_byte};
    cnt_next  = cnt + 32'd1;
    head_pop  = emit && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      acc       <= '0;
      cnt       <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= last ? 2'd0 : idx + 2'd1;
      if (head.invalid || done) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= hash_next;
        cnt <= cnt_next;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte     <= cur_byte;
      last_of_run  <= last;
      string_done  <= done;
      invalid_code <= head.invalid;
      byte_length  <= done ? cnt_next : 32'd0;
      string_hash  <= done ? (hash_next | HashTag) : 32'd0;
    end
  end

endmodule

@@ hw/rtl/utf8_encoder_with_string_hash_top.sv @@
// UTF-8 encoder with running string hash. Each pushed code point yields one to four
// encoded bytes, one per pop, the last flagged by last_of_run; a code point of 0x110000
// or above yields a single zero byte with invalid_code set and restarts the string. On
// the final byte of a code point pushed with end_of_string, string_done is set and
// byte_length and string_hash (acc*31+byte mod 2^32, bit 31 set) cover the whole string.
// Throughput is one byte per cycle while pop is held high; a four-entry queue of encoded
// code points lets input and output stall independently. With nothing ahead of it, a
// pushed code point is first written into the queue, then its first byte is registered
// onto the outputs.
module utf8_encoder_with_string_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] code_point,
  input  logic        end_of_string,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        string_done,
  output logic [31:0] byte_length,
  output logic [31:0] string_hash,
  output logic        invalid_code
);
  import u8h_pkg::*;

  item_t in_item;
  item_t head;
  logic  head_valid;
  logic  head_pop;
  logic  wr_en;

  assign wr_en = push && !full;

  u8h_front u_front (
    .code_point    (code_point),
    .end_of_string (end_of_string),
    .item          (in_item)
  );

  u8h_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_item  (in_item),
    .full     (full),
    .rd_en    (head_pop),
    .rd_item  (head),
    .rd_valid (head_valid)
  );

  u8h_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .string_done  (string_done),
    .byte_length  (byte_length),
    .string_hash  (string_hash),
    .invalid_code (invalid_code)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && string_done |-> last_of_run && !invalid_code && string_hash[31])
    else $error("string_done without last byte or hash tag");

  a_invalid_form: assert property (@(posedge clk) disable iff (rst)
    !empty && invalid_code |-> last_of_run && out_byte == 8'h00 && !string_done)
    else $error("malformed error result");

  a_no_stats: assert property (@(posedge clk) disable iff (rst)
    !empty && !string_done |-> byte_length == 32'd0 && string_hash == 32'd0)
    else $error("length or hash present without string_done");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(last_of_run))
    else $error("result changed while stalled");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    head_pop |=> !empty && last_of_run)
    else $error("queue entry retired without its last byte");

endmodule

@@ tb/sv/utf8_encoder_with_string_hash_top_test.sv @@
module utf8_encoder_with_string_hash_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u8h_pkg::*;

  localparam logic [31:0] HashMult = 32'd31;
  localparam int          NumItems = 310;
  localparam int          DrainCycles = 10;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        done;
    logic [31:0] nbytes;
    logic [31:0] hash;
    logic        bad;
  } enc_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] code_point = '0;
  logic        end_of_string = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        string_done;
  logic [31:0] byte_length;
  logic [31:0] string_hash;
  logic        invalid_code;

  // predicted string state
  logic [31:0] str_hash = '0;
  logic [31:0] str_len = '0;
  enc_byte_t   expected_bytes[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;

  int mismatches = 0;
  int code_points_sent = 0;
  int bytes_checked = 0;
  int strings_closed = 0;
  int bad_points = 0;

  utf8_encoder_with_string_hash_top dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .code_point    (code_point),
    .end_of_string (end_of_string),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .string_done   (string_done),
    .byte_length   (byte_length),
    .string_hash   (string_hash),
    .invalid_code  (invalid_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void encode_code_point(logic [31:0] cp, logic eos);
    logic [7:0] seq [4];
    len_t       sz;
    enc_byte_t  r;
    r = '0;
    if (cp >= CpLimit) begin
      r.last = 1'b1;
      r.bad  = 1'b1;
      expected_bytes.push_back(r);
      str_hash = '0;
      str_len  = '0;
      bad_points++;
      return;
    end
    if (cp < Cp2Byte) begin
      sz = LEN_1;
      seq[0] = cp[7:0];
    end else if (cp < Cp3Byte) begin
      sz = LEN_2;
      seq[0] = Lead2 | 8'(cp[10:6]);
      seq[1] = Cont | 8'(cp[5:0]);
    end else if (cp < Cp4Byte) begin
      sz = LEN_3;
      seq[0] = Lead3 | 8'(cp[15:12]);
      seq[1] = Cont | 8'(cp[11:6]);
      seq[2] = Cont | 8'(cp[5:0]);
    end else begin
      sz = LEN_4;
      seq[0] = Lead4 | 8'(cp[20:18]);
      seq[1] = Cont | 8'(cp[17:12]);
      seq[2] = Cont | 8'(cp[11:6]);
      seq[3] = Cont | 8'(cp[5:0]);
    end
    for (int k = 0; k <= int'(sz); k++) begin
      str_hash = str_hash * HashMult + 32'(seq[k]);
      str_len  = str_len + 32'd1;
      r = '0;
      r.data = seq[k];
      if (k == int'(sz)) begin
        r.last = 1'b1;
        if (eos) begin
          r.done   = 1'b1;
          r.nbytes = str_len;
          r.hash   = str_hash | HashTag;
        end
      end
      expected_bytes.push_back(r);
    end
    if (eos) begin
      str_hash = '0;
      str_len  = '0;
      strings_closed++;
    end
  endfunction

  function automatic logic [31:0] random_code_point();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)      return $urandom_range(0, 32'h7F);
    else if (sel < 50) return $urandom_range(32'h80, 32'h7FF);
    else if (sel < 68) return $urandom_range(32'h800, 32'hFFFF);
    else if (sel < 74) return $urandom_range(32'hD800, 32'hDFFF);
    else if (sel < 92) return $urandom_range(32'h1_0000, 32'h10_FFFF);
    else if (sel < 96) return $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
    else               return $urandom;
  endfunction

  // push stays high after a transfer; the next call lowers it or reloads it
  task automatic send_code_point(input logic [31:0] cp, input logic eos);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    code_point    <= cp;
    end_of_string <= eos;
    do @(posedge clk); while (full);
    encode_code_point(cp, eos);
    code_points_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic check_byte();
    enc_byte_t exp;
    bytes_checked++;
    if (expected_bytes.size() == 0) begin
      $error("unexpected transfer: out_byte %h last_of_run %b invalid_code %b",
             out_byte, last_of_run, invalid_code);
      mismatches++;
      return;
    end
    exp = expected_bytes.pop_front();
    if (out_byte !== exp.data) begin
      $error("out_byte: expected %h, got %h", exp.data, out_byte);
      mismatches++;
    end
    if (last_of_run !== exp.last) begin
      $error("last_of_run: expected %b, got %b", exp.last, last_of_run);
      mismatches++;
    end
    if (string_done !== exp.done) begin
      $error("string_done: expected %b, got %b", exp.done, string_done);
      mismatches++;
    end
    if (byte_length !== exp.nbytes) begin
      $error("byte_length: expected %0d, got %0d", exp.nbytes, byte_length);
      mismatches++;
    end
    if (string_hash !== exp.hash) begin
      $error("string_hash: expected %h, got %h", exp.hash, string_hash);
      mismatches++;
    end
    if (invalid_code !== exp.bad) begin
      $error("invalid_code: expected %b, got %b", exp.bad, invalid_code);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    int gap;
    wait (!rst);
    forever begin
      if (rx_hold > 0) begin
        pop <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_byte();
    end
  end

  // length boundaries, surrogates, invalid points mid-string and at the end
  task automatic test_directed();
    send_code_point(32'h0000_0000, 1'b0);
    send_code_point(32'h0000_007F, 1'b0);
    send_code_point(32'h0000_0080, 1'b0);
    send_code_point(32'h0000_07FF, 1'b0);
    send_code_point(32'h0000_0800, 1'b0);
    send_code_point(32'h0000_FFFF, 1'b1);
    send_code_point(32'h0000_D800, 1'b0);
    send_code_point(32'h0000_DFFF, 1'b0);
    send_code_point(32'h0001_0000, 1'b0);
    send_code_point(32'h0010_FFFF, 1'b1);
    send_code_point(32'h0000_0041, 1'b1);
    send_code_point(32'h0000_20AC, 1'b0);
    send_code_point(32'h0011_0000, 1'b0);
    send_code_point(32'h0000_0061, 1'b1);
    send_code_point(32'hFFFF_FFFF, 1'b1);
    send_code_point(32'h0005_A5A5, 1'b0);
    send_code_point(32'hAAAA_AAAA, 1'b0);
    send_code_point(32'h0005_5555, 1'b1);
    send_code_point(32'h0010_FFFF, 1'b0);
    send_code_point(32'h0011_0000, 1'b1);
    wait_drained();
  endtask

  // sink holds off long enough for the queue to fill and full to assert
  task automatic test_output_stall();
    tx_idle = 1'b0;
    rx_hold = 120;
    for (int i = 0; i < 24; i++)
      send_code_point($urandom_range(32'h1_0000, 32'h10_FFFF), (i % 6) == 5);
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_strings();
    int len;
    while (code_points_sent < NumItems) begin
      len = $urandom_range(1, 12);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      for (int i = 0; i < len; i++)
        send_code_point(random_code_point(), i == len - 1);
      if ($urandom_range(0, 15) == 0)
        wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_stall();
    test_random_strings();
    repeat (DrainCycles) @(posedge clk);
    $display("Encoded %0d code points into %0d checked bytes: %0d strings closed,",
             code_points_sent, bytes_checked, strings_closed);
    $display("%0d invalid code points, with input and output stalls.", bad_points);
    if (mismatches == 0) begin
      $display("utf8_encoder_with_string_hash_top_test: PASS");
    end else begin
      $display("utf8_encoder_with_string_hash_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("Timeout with %0d bytes still expected", expected_bytes.size());
    $display("utf8_encoder_with_string_hash_top_test: FAIL");
    $finish;
  end

endmodule

@@ utf8_encoder_with_string_hash_top.f @@
hw/rtl/u8h_pkg.sv
hw/rtl/u8h_front.sv
hw/rtl/u8h_queue.sv
hw/rtl/u8h_back.sv
hw/rtl/utf8_encoder_with_string_hash_top.sv
tb/sv/utf8_encoder_with_string_hash_top_test.sv
